// ===== hdl/u2s_pkg.sv =====
// shared types and constants for the utf-8 to ucs-2 stream decoder
// no dependencies; imported by every module of the block
package u2s_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] MALFORMED_CODE = 16'h22E0;

  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_CONT,
    CLS_BAD
  } byte_cls_e;

  typedef enum logic [1:0] {
    ST_CHAR  = 2'd0,
    ST_NUL   = 2'd1,
    ST_BAD   = 2'd2,
    ST_LIMIT = 2'd3
  } status_e;

  // one classified beat travelling from front to back
  typedef struct packed {
    byte_cls_e  cls;
    logic [6:0] bits;
  } item_t;

endpackage

// ===== hdl/utf8_to_ucs2_stream_decoder.sv =====
// top level of the utf-8 to ucs-2 stream decoder: front, queue and back
// depends on u2s_pkg, u2s_front, u2s_queue, u2s_back
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  input    | in_valid_i / in_stall_o  | text_byte_i[7:0]
//  output   | out_valid_o / out_stall_i| code_unit_o[15:0] status_o[1:0]
//           |                          | char_count_o[15:0]
//  config   | cfg_valid_i / cfg_ready_o| cfg_data_i[15:0] (max_chars)
//
// one byte per cycle sustained while out_stall_i is low; a taken byte is written into
// the queue, then the back end decodes it into the output register when it pops
// reset clears decode state, max_chars and both queue and output valid flags
// out_stall_i holds the output register; the two-entry queue then fills and
// in_stall_o rises, bytes that produce no result still drain while output is free
module utf8_to_ucs2_stream_decoder import u2s_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic [1:0]  status_o,
  output logic [15:0] char_count_o
);

  logic  q_full;
  logic  q_valid;
  logic  push;
  logic  pop;
  item_t push_item;
  item_t pop_item;

  assign cfg_ready_o = 1'b1;

  u2s_front u_front (
    .in_valid_i  (in_valid_i),
    .text_byte_i (text_byte_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .item_o      (push_item)
  );

  u2s_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  u2s_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i & cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .q_valid_i    (q_valid),
    .q_item_i     (pop_item),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .code_unit_o  (code_unit_o),
    .status_o     (status_o),
    .char_count_o (char_count_o)
  );

endmodule

// ===== hdl/u2s_front.sv =====
// front end: accepts raw bytes and classifies them into queue items
// depends on u2s_pkg
module u2s_front import u2s_pkg::*; (
  input  logic       in_valid_i,
  input  logic [7:0] text_byte_i,
  input  logic       q_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output item_t      item_o
);

  always_comb begin
    item_o.bits = text_byte_i[6:0];
    if (text_byte_i == 8'h00) begin
      item_o.cls = CLS_NUL;
    end else if (text_byte_i[7] == 1'b0) begin
      item_o.cls = CLS_ASCII;
    end else if (text_byte_i[7:6] == 2'b10) begin
      item_o.cls = CLS_CONT;
    end else if (text_byte_i[7:5] == 3'b110) begin
      item_o.cls = CLS_LEAD2;
    end else if (text_byte_i[7:4] == 4'b1110) begin
      item_o.cls = CLS_LEAD3;
    end else begin
      item_o.cls = CLS_BAD;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

endmodule

// ===== hdl/u2s_queue.sv =====
// short queue of classified beats between front and back
// depends on u2s_pkg
module u2s_queue import u2s_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o
);

  localparam logic [QPTR_BITS:0] DEPTH_CNT = (QPTR_BITS+1)'(QUEUE_DEPTH);

  item_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_BITS:0]   cnt_q, cnt_d;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    logic [QPTR_BITS-1:0] r;
    if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) r = '0;
    else                                  r = p + 1'b1;
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign full_o  = (cnt_q == DEPTH_CNT);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

endmodule

// ===== hdl/u2s_back.sv =====
// back end: sequence assembly, character count, limit check and output register
// depends on u2s_pkg
module u2s_back import u2s_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        pop_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [15:0] code_unit_o,
  output logic [1:0]  status_o,
  output logic [15:0] char_count_o
);

  localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [15:0]           max_chars_q;
  logic [1:0]            pending_q, pending_d;
  logic [11:0]           partial_q, partial_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  skip_q, skip_d;

  logic                  out_valid_q, out_valid_d;
  logic [15:0]           code_q, code_d;
  status_e               status_q, status_d;
  logic [15:0]           count_q, count_d;

  logic                  has_res;
  logic                  finish;
  logic [15:0]           fin_code;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [CMP_BITS-1:0]   cnt_inc_w;
  logic [CMP_BITS-1:0]   cnt_cur_w;
  logic                  limit_hit;

  // a beat leaves the queue whenever the output register can take a result
  assign pop_o = q_valid_i & (~out_valid_q | ~out_stall_i);

  assign cnt_inc   = (cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_inc_w = CMP_BITS'(cnt_inc);
  assign cnt_cur_w = CMP_BITS'(cnt_q);
  assign limit_hit = (max_chars_q != 16'd0) && (CMP_BITS'(max_chars_q) == cnt_inc_w);

  function automatic logic [15:0] sat16(input logic [CMP_BITS-1:0] v);
    logic [15:0] r;
    if (v > CMP_BITS'(16'hFFFF)) r = 16'hFFFF;
    else                         r = v[15:0];
    return r;
  endfunction

  always_comb begin
    pending_d = pending_q;
    partial_d = partial_q;
    cnt_d     = cnt_q;
    skip_d    = skip_q;
    has_res   = 1'b0;
    finish    = 1'b0;
    fin_code  = 16'd0;
    code_d    = code_q;
    status_d  = status_q;
    count_d   = count_q;

    if (skip_q) begin
      if (q_item_i.cls == CLS_NUL) begin
        skip_d    = 1'b0;
        cnt_d     = '0;
        pending_d = 2'd0;
        partial_d = 12'd0;
      end
    end else if (pending_q != 2'd0) begin
      if (q_item_i.cls == CLS_CONT) begin
        pending_d = pending_q - 2'd1;
        if (pending_q == 2'd1) begin
          fin_code  = {partial_q[9:0], q_item_i.bits[5:0]};
          partial_d = 12'd0;
          finish    = 1'b1;
        end else begin
          partial_d = {partial_q[5:0], q_item_i.bits[5:0]};
        end
      end else begin
        // sequence cut short; a NUL here also closes the string
        has_res   = 1'b1;
        code_d    = MALFORMED_CODE;
        status_d  = ST_BAD;
        count_d   = sat16(cnt_cur_w);
        pending_d = 2'd0;
        partial_d = 12'd0;
        if (q_item_i.cls == CLS_NUL) cnt_d = '0;
        else                         skip_d = 1'b1;
      end
    end else begin
      case (q_item_i.cls)
        CLS_NUL: begin
          has_res  = 1'b1;
          code_d   = 16'd0;
          status_d = ST_NUL;
          count_d  = sat16(cnt_cur_w);
          cnt_d    = '0;
        end
        CLS_ASCII: begin
          fin_code = {9'd0, q_item_i.bits};
          finish   = 1'b1;
        end
        CLS_LEAD2: begin
          partial_d = {7'd0, q_item_i.bits[4:0]};
          pending_d = 2'd1;
        end
        CLS_LEAD3: begin
          partial_d = {8'd0, q_item_i.bits[3:0]};
          pending_d = 2'd2;
        end
        default: begin
          has_res  = 1'b1;
          code_d   = MALFORMED_CODE;
          status_d = ST_BAD;
          count_d  = sat16(cnt_cur_w);
          skip_d   = 1'b1;
        end
      endcase
    end

    if (finish) begin
      has_res  = 1'b1;
      cnt_d    = cnt_inc;
      code_d   = fin_code;
      count_d  = sat16(cnt_inc_w);
      status_d = limit_hit ? ST_LIMIT : ST_CHAR;
      if (limit_hit) skip_d = 1'b1;
    end

    out_valid_d = pop_o ? has_res : (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= 16'd0;
      pending_q   <= 2'd0;
      partial_q   <= 12'd0;
      cnt_q       <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_chars_q <= cfg_data_i;
      end
      if (pop_o) begin
        pending_q <= pending_d;
        partial_q <= partial_d;
        cnt_q     <= cnt_d;
        skip_q    <= skip_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && has_res) begin
      code_q   <= code_d;
      status_q <= status_d;
      count_q  <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_unit_o  = code_q;
  assign status_o     = status_q;
  assign char_count_o = count_q;

endmodule
